// File: rtl/ccr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccr_pkg
// Shared types and codes of the capture command responder.
// ---------------------------------------------------------------------------
package ccr_pkg;

  // Input word kinds
  localparam logic [1:0] CMD_HOST       = 2'd0;
  localparam logic [1:0] CMD_DISCONNECT = 2'd1;
  localparam logic [1:0] CMD_UPD_BEGIN  = 2'd2;
  localparam logic [1:0] CMD_UPD_END    = 2'd3;

  // Host request codes
  localparam logic [7:0] REQ_CAPTURE = 8'd0;
  localparam logic [7:0] REQ_STOP    = 8'd1;
  localparam logic [7:0] REQ_STATUS  = 8'd2;
  localparam logic [7:0] REQ_REBOOT  = 8'd3;

  // Reply kinds
  localparam logic [1:0] KIND_HOST  = 2'd0;
  localparam logic [1:0] KIND_GRANT = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;

  // Outcome codes
  localparam logic [2:0] RES_OK       = 3'd0;
  localparam logic [2:0] RES_INVALID  = 3'd1;
  localparam logic [2:0] RES_SPEED    = 3'd2;
  localparam logic [2:0] RES_INTERNAL = 3'd3;
  localparam logic [2:0] RES_CONFLICT = 3'd4;

  // Mode codes
  localparam logic [2:0] MODE_PAUSED    = 3'd0;
  localparam logic [2:0] MODE_CAPTURING = 3'd1;
  localparam logic [2:0] MODE_ERROR     = 3'd3;
  localparam logic [2:0] MODE_UPDATING  = 3'd4;

  // Link speed codes
  localparam logic [1:0] SPD_UNKNOWN = 2'd0;
  localparam logic [1:0] SPD_FULL    = 2'd1;
  localparam logic [1:0] SPD_HIGH    = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  request_code;
    logic [7:0]  sequence_req;
    logic [1:0]  link_speed;
    logic        start_ok;
    logic        stop_ok;
    logic [63:0] queued_bytes;
    logic [63:0] dropped_bytes;
    logic [63:0] discard_bytes;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [7:0]  reply_sequence;
    logic [7:0]  reply_code;
    logic [2:0]  outcome;
    logic [2:0]  mode_now;
    logic [1:0]  reply_speed;
    logic [31:0] capture_number;
    logic [31:0] reply_time_ms;
    logic [63:0] stop_discarded;
    logic [63:0] host_expected;
    logic [63:0] local_dropped;
    logic        reboot_request;
  } out_item_t;

endpackage

// File: rtl/ccr_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccr_in_if
// Valid/ready channel carrying one input word.
// ---------------------------------------------------------------------------
interface ccr_in_if;
  logic              valid;
  logic              ready;
  ccr_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ccr_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccr_out_if
// Valid/ready channel carrying one result word.
// ---------------------------------------------------------------------------
interface ccr_out_if;
  logic               valid;
  logic               ready;
  ccr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ccr_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ccr_core
// Mode, capture counter and response cache; builds the reply for one word.
// ---------------------------------------------------------------------------
module ccr_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  ccr_pkg::in_item_t  item,
  output ccr_pkg::out_item_t reply
);

  typedef struct packed {
    logic [7:0]  seq;
    logic [7:0]  code;
    logic [2:0]  outcome;
    logic [2:0]  mode;
    logic [1:0]  speed;
    logic [31:0] capture;
    logic [31:0] time_ms;
    logic [63:0] discarded;
    logic [63:0] expected;
    logic [63:0] dropped;
  } cache_t;

  logic [2:0]  mode_r, mode_nxt;
  logic [31:0] capture_r, capture_nxt;
  logic        cache_valid_r;
  cache_t      cache_r, cache_nxt;
  logic        cache_wr;
  logic [1:0]  spd;
  logic [31:0] cap_inc;
  logic [2:0]  res;
  logic [63:0] dis, expd, drop;
  logic        reboot;

  // Map the link speed; code three reads as unknown
  always_comb begin
    if (item.link_speed == ccr_pkg::SPD_FULL || item.link_speed == ccr_pkg::SPD_HIGH) begin
      spd = item.link_speed;
    end else begin
      spd = ccr_pkg::SPD_UNKNOWN;
    end
  end

  // Advance the capture counter, skipping zero on wrap
  always_comb begin
    cap_inc = capture_r + 32'd1;
    if (cap_inc == 32'd0) begin
      cap_inc = 32'd1;
    end
  end

  // Decode the word and build next state and reply
  always_comb begin
    mode_nxt    = mode_r;
    capture_nxt = capture_r;
    cache_wr    = 1'b0;
    res         = ccr_pkg::RES_OK;
    dis         = 64'd0;
    expd        = 64'd0;
    drop        = 64'd0;
    reboot      = 1'b0;

    reply.reply_kind     = ccr_pkg::KIND_HOST;
    reply.reply_sequence = 8'd0;
    reply.reply_code     = 8'd0;
    reply.outcome        = ccr_pkg::RES_OK;
    reply.mode_now       = mode_r;
    reply.reply_speed    = spd;
    reply.capture_number = capture_r;
    reply.reply_time_ms  = item.time_ms;
    reply.stop_discarded = 64'd0;
    reply.host_expected  = 64'd0;
    reply.local_dropped  = 64'd0;
    reply.reboot_request = 1'b0;

    case (item.command)
      ccr_pkg::CMD_DISCONNECT, ccr_pkg::CMD_UPD_END: begin
        mode_nxt         = ccr_pkg::MODE_PAUSED;
        reply.reply_kind = ccr_pkg::KIND_ACK;
        reply.mode_now   = ccr_pkg::MODE_PAUSED;
      end
      ccr_pkg::CMD_UPD_BEGIN: begin
        reply.reply_kind = ccr_pkg::KIND_GRANT;
        if (mode_r == ccr_pkg::MODE_PAUSED) begin
          mode_nxt       = ccr_pkg::MODE_UPDATING;
          reply.mode_now = ccr_pkg::MODE_UPDATING;
        end else begin
          reply.outcome = ccr_pkg::RES_INVALID;
        end
      end
      default: begin
        reply.reply_sequence = item.sequence_req;
        reply.reply_code     = item.request_code;
        if (cache_valid_r && item.sequence_req == cache_r.seq) begin
          if (item.request_code == cache_r.code) begin
            // replay the cached response
            reply.outcome        = cache_r.outcome;
            reply.mode_now       = cache_r.mode;
            reply.reply_speed    = cache_r.speed;
            reply.capture_number = cache_r.capture;
            reply.reply_time_ms  = cache_r.time_ms;
            reply.stop_discarded = cache_r.discarded;
            reply.host_expected  = cache_r.expected;
            reply.local_dropped  = cache_r.dropped;
          end else begin
            reply.outcome = ccr_pkg::RES_CONFLICT;
          end
        end else begin
          cache_wr = 1'b1;
          case (item.request_code)
            ccr_pkg::REQ_CAPTURE: begin
              if (mode_r != ccr_pkg::MODE_PAUSED) begin
                res = ccr_pkg::RES_INVALID;
              end else if (spd != ccr_pkg::SPD_HIGH) begin
                res = ccr_pkg::RES_SPEED;
              end else if (!item.start_ok) begin
                mode_nxt = ccr_pkg::MODE_ERROR;
                res      = ccr_pkg::RES_INTERNAL;
              end else begin
                mode_nxt    = ccr_pkg::MODE_CAPTURING;
                capture_nxt = cap_inc;
              end
            end
            ccr_pkg::REQ_STOP: begin
              if (mode_r != ccr_pkg::MODE_CAPTURING) begin
                res = ccr_pkg::RES_INVALID;
              end else if (!item.stop_ok) begin
                mode_nxt = ccr_pkg::MODE_ERROR;
                res      = ccr_pkg::RES_INTERNAL;
              end else begin
                mode_nxt = ccr_pkg::MODE_PAUSED;
                dis      = item.discard_bytes;
                expd     = item.queued_bytes - item.discard_bytes;
                drop     = item.dropped_bytes;
              end
            end
            ccr_pkg::REQ_STATUS: begin
              res = ccr_pkg::RES_OK;
            end
            ccr_pkg::REQ_REBOOT: begin
              if (mode_r != ccr_pkg::MODE_PAUSED) begin
                res = ccr_pkg::RES_INVALID;
              end else begin
                reboot = 1'b1;
              end
            end
            default: begin
              res = ccr_pkg::RES_INTERNAL;
            end
          endcase
          reply.outcome        = res;
          reply.mode_now       = mode_nxt;
          reply.capture_number = capture_nxt;
          reply.stop_discarded = dis;
          reply.host_expected  = expd;
          reply.local_dropped  = drop;
          reply.reboot_request = reboot;
        end
      end
    endcase
  end

  // Collect the fresh response for the cache
  always_comb begin
    cache_nxt.seq       = item.sequence_req;
    cache_nxt.code      = item.request_code;
    cache_nxt.outcome   = res;
    cache_nxt.mode      = mode_nxt;
    cache_nxt.speed     = spd;
    cache_nxt.capture   = capture_nxt;
    cache_nxt.time_ms   = item.time_ms;
    cache_nxt.discarded = dis;
    cache_nxt.expected  = expd;
    cache_nxt.dropped   = drop;
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= ccr_pkg::MODE_PAUSED;
      capture_r     <= 32'd0;
      cache_valid_r <= 1'b0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      capture_r <= capture_nxt;
      if (cache_wr) begin
        cache_valid_r <= 1'b1;
      end
    end
  end

  // Hold cached response payload
  always_ff @(posedge clk) begin
    if (step && cache_wr) begin
      cache_r <= cache_nxt;
    end
  end

endmodule

// File: rtl/capture_command_responder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// capture_command_responder
// Answers host requests and link/update events, one result word per input.
// ---------------------------------------------------------------------------
//   port     dir   word        handshake
//   in_ch    in    in_item_t   valid/ready, taken when both high
//   out_ch   out   out_item_t  valid/ready, taken when both high
//
// One word per cycle sustained while the output is ready; a taken word goes
// to the input register, then to the result register. The decode and cache
// compare sit between the input register and the result register. Reset is
// synchronous, active low, and leaves the block paused with an empty cache.
// A stalled output keeps the input register full, which then drops
// in_ch.ready.
// ---------------------------------------------------------------------------
module capture_command_responder (
  input  logic      clk,
  input  logic      rst_n,
  ccr_in_if.sink    in_ch,
  ccr_out_if.source out_ch
);

  ccr_pkg::in_item_t  in_r;
  logic               in_vld_r;
  ccr_pkg::out_item_t out_r;
  ccr_pkg::out_item_t reply;
  logic               out_vld_r;
  logic               advance;

  // Move a word from input to result register when the result slot frees
  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  ccr_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_r),
    .reply (reply)
  );

  // Track occupancy of both registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Load payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r <= in_ch.data;
    end
    if (advance) begin
      out_r <= reply;
    end
  end

  // A moved word always shows up at the output
  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("result register not filled after advance");

  // A blocked input word is kept
  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> in_vld_r)
    else $error("input word lost while stalled");

  // Reboot is flagged only on an accepted reboot request
  a_reboot_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.reboot_request) |->
      (out_r.outcome == ccr_pkg::RES_OK && out_r.reply_code == ccr_pkg::REQ_REBOOT
       && out_r.reply_kind == ccr_pkg::KIND_HOST))
    else $error("reboot flagged on a non-reboot reply");

  // Capturing always reports a nonzero capture number
  a_capture_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.mode_now == ccr_pkg::MODE_CAPTURING) |->
      (out_r.capture_number != 32'd0))
    else $error("capturing with zero capture number");

endmodule
